>>> design/assert_macros.svh
// Assertion macros used by the top-level design file of the cipher block.
// No dependencies; each macro collapses to nothing when NO_ASSERTIONS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

>>> design/sbrc_pkg.sv
// Shared constants and types of the substitution-rotate block cipher.
// Used by every module of the block but sbrc_ram; depends on nothing.
package sbrc_pkg;

   localparam int BLOCK_W   = 64;
   localparam int BYTE_W    = 8;
   localparam int NUM_BYTES = BLOCK_W / BYTE_W;
   localparam int SEL_W     = 3;
   localparam int TBL_DEPTH = 256;

   localparam int ROUNDS = 16;
   localparam int CNT_W  = $clog2(ROUNDS + 1);

   localparam logic [1:0] CMD_ENCRYPT = 2'd0;
   localparam logic [1:0] CMD_DECRYPT = 2'd1;
   localparam logic [1:0] CMD_LOAD    = 2'd2;

   typedef struct packed {
      logic              rd_en;
      logic              inverse;
      logic              wr_en;
      logic [SEL_W-1:0]  wr_sel;
      logic [BYTE_W-1:0] wr_idx;
      logic [BYTE_W-1:0] wr_val;
   } tbl_ctrl_type;

endpackage

>>> design/sbrc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependencies.
module sbrc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/sbrc_tables.sv
// Forward and inverse substitution tables: one RAM per byte position and direction.
// Depends on sbrc_pkg and sbrc_ram.
module sbrc_tables (
   input  logic                          clock,
   input  sbrc_pkg::tbl_ctrl_type        ctrl,
   input  logic [sbrc_pkg::BLOCK_W-1:0]  rd_addr,
   output logic [sbrc_pkg::BLOCK_W-1:0]  rd_data
);

   logic [sbrc_pkg::BLOCK_W-1:0] fwd_data;
   logic [sbrc_pkg::BLOCK_W-1:0] inv_data;

   for (genvar k = 0; k < sbrc_pkg::NUM_BYTES; k++) begin : g_byte
      localparam int HI = sbrc_pkg::BLOCK_W - 1 - k * sbrc_pkg::BYTE_W;
      logic wr_here;

      assign wr_here = ctrl.wr_en && (ctrl.wr_sel == sbrc_pkg::SEL_W'(k));

      // A load writes value at index in the forward table and index at value
      // in the inverse table, so both stay in step.
      sbrc_ram #(
         .WIDTH (sbrc_pkg::BYTE_W),
         .DEPTH (sbrc_pkg::TBL_DEPTH)
      ) u_fwd (
         .clock   (clock),
         .wr_en   (wr_here),
         .wr_addr (ctrl.wr_idx),
         .wr_data (ctrl.wr_val),
         .rd_en   (ctrl.rd_en && !ctrl.inverse),
         .rd_addr (rd_addr[HI -: sbrc_pkg::BYTE_W]),
         .rd_data (fwd_data[HI -: sbrc_pkg::BYTE_W])
      );

      sbrc_ram #(
         .WIDTH (sbrc_pkg::BYTE_W),
         .DEPTH (sbrc_pkg::TBL_DEPTH)
      ) u_inv (
         .clock   (clock),
         .wr_en   (wr_here),
         .wr_addr (ctrl.wr_val),
         .wr_data (ctrl.wr_idx),
         .rd_en   (ctrl.rd_en && ctrl.inverse),
         .rd_addr (rd_addr[HI -: sbrc_pkg::BYTE_W]),
         .rd_data (inv_data[HI -: sbrc_pkg::BYTE_W])
      );
   end

   assign rd_data = ctrl.inverse ? inv_data : fwd_data;

endmodule

>>> design/sbrc_round.sv
// Round datapath: finishes the previous round from table data and forms the next
// table address. Depends on sbrc_pkg.
module sbrc_round (
   input  logic                          decrypt,
   input  logic                          first,
   input  logic [sbrc_pkg::BLOCK_W-1:0]  block,
   input  logic [sbrc_pkg::BLOCK_W-1:0]  tbl_data,
   input  logic [sbrc_pkg::BLOCK_W-1:0]  key,
   output logic [sbrc_pkg::BLOCK_W-1:0]  tbl_addr,
   output logic [sbrc_pkg::BLOCK_W-1:0]  result
);

   logic [sbrc_pkg::BLOCK_W-1:0] finished;
   logic [sbrc_pkg::BLOCK_W-1:0] cur;

   // Tail of a round: encrypt rotates left, decrypt applies the key.
   assign finished = decrypt ? (tbl_data ^ key)
                             : {tbl_data[sbrc_pkg::BLOCK_W-2:0],
                                tbl_data[sbrc_pkg::BLOCK_W-1]};

   assign cur = first ? block : finished;

   // Head of a round: encrypt applies the key, decrypt rotates right.
   assign tbl_addr = decrypt ? {cur[0], cur[sbrc_pkg::BLOCK_W-1:1]} : (cur ^ key);

   assign result = finished;

endmodule

>>> design/sbox_rotate_block_cipher_unit.sv
// Substitution-rotate block cipher, top level with the round sequencer.
// An encrypt or decrypt block runs ROUNDS rounds, one registered table read per round,
// then a finishing state that waits for the output register to be free; the next block
// transfers only once the sequencer is back in idle.
// A table load is accepted only in idle and produces no result.
// Reset is synchronous: it clears the key and control state; table RAMs are not cleared.
`include "assert_macros.svh"

module sbox_rotate_block_cipher_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_command,
   input  logic [sbrc_pkg::BLOCK_W-1:0]  req_block_in,
   input  logic [sbrc_pkg::SEL_W-1:0]    req_table_select,
   input  logic [sbrc_pkg::BYTE_W-1:0]   req_table_index,
   input  logic [sbrc_pkg::BYTE_W-1:0]   req_table_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sbrc_pkg::BLOCK_W-1:0]  rsp_block_out,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sbrc_pkg::BLOCK_W-1:0]  csr_cipher_key
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]                    state_ff, state_in;
   logic [sbrc_pkg::CNT_W-1:0]    count_ff, count_in;
   logic                          decrypt_ff, decrypt_in;
   logic [sbrc_pkg::BLOCK_W-1:0]  block_ff, block_in;
   logic [sbrc_pkg::BLOCK_W-1:0]  key_ff, key_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [sbrc_pkg::BLOCK_W-1:0]  rsp_block_ff, rsp_block_in;

   logic                          req_xfer;
   logic                          is_crypt;
   logic                          slot_free;
   logic                          last_round;
   sbrc_pkg::tbl_ctrl_type        tbl_ctrl;
   logic [sbrc_pkg::BLOCK_W-1:0]  tbl_addr;
   logic [sbrc_pkg::BLOCK_W-1:0]  tbl_data;
   logic [sbrc_pkg::BLOCK_W-1:0]  round_result;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign is_crypt  = (req_command == sbrc_pkg::CMD_ENCRYPT) ||
                      (req_command == sbrc_pkg::CMD_DECRYPT);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign last_round = (count_ff == sbrc_pkg::CNT_W'(sbrc_pkg::ROUNDS - 1));

   assign csr_ready = 1'b1;

   always_comb begin
      tbl_ctrl.rd_en   = (state_ff == ST_RUN);
      tbl_ctrl.inverse = decrypt_ff;
      tbl_ctrl.wr_en   = req_xfer && (req_command == sbrc_pkg::CMD_LOAD);
      tbl_ctrl.wr_sel  = req_table_select;
      tbl_ctrl.wr_idx  = req_table_index;
      tbl_ctrl.wr_val  = req_table_value;
   end

   sbrc_tables u_tables (
      .clock   (clock),
      .ctrl    (tbl_ctrl),
      .rd_addr (tbl_addr),
      .rd_data (tbl_data)
   );

   sbrc_round u_round (
      .decrypt  (decrypt_ff),
      .first    (count_ff == '0),
      .block    (block_ff),
      .tbl_data (tbl_data),
      .key      (key_ff),
      .tbl_addr (tbl_addr),
      .result   (round_result)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      decrypt_in   = decrypt_ff;
      block_in     = block_ff;
      key_in       = key_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_block_in = rsp_block_ff;

      if (csr_valid && csr_ready) begin
         key_in = csr_cipher_key;
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && is_crypt) begin
               state_in   = ST_RUN;
               count_in   = '0;
               decrypt_in = (req_command == sbrc_pkg::CMD_DECRYPT);
               block_in   = req_block_in;
            end
         end
         ST_RUN: begin
            count_in = count_ff + 1'b1;
            if (last_round) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // The table read data holds here until the output register frees up.
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_block_in = round_result;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         key_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         key_ff       <= key_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      decrypt_ff   <= decrypt_in;
      block_ff     <= block_in;
      rsp_block_ff <= rsp_block_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_block_out = rsp_block_ff;

   `ASSERT_PROP(a_start_run, clock, reset,
      req_xfer && is_crypt |=> state_ff == ST_RUN && count_ff == '0,
      "Block transfer did not start the round sequence")
   `ASSERT_PROP(a_count_range, clock, reset,
      state_ff == ST_RUN |-> count_ff < sbrc_pkg::CNT_W'(sbrc_pkg::ROUNDS),
      "Round count ran past the last round")
   `ASSERT_PROP(a_result_source, clock, reset,
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE,
      "Result appeared without a finished block")
   `ASSERT_PROP(a_done_exit, clock, reset,
      state_ff == ST_DONE && slot_free |=> state_ff == ST_IDLE && rsp_valid_ff,
      "Finished block was not handed to the output register")
   `ASSERT_NEVER(a_load_no_result, clock, reset,
      req_xfer && req_command == sbrc_pkg::CMD_LOAD && state_ff != ST_IDLE,
      "Table load accepted while a block is in flight")

endmodule
